@@ rtl/core/lbpc_pkg.sv @@
// Package for the LED blink pattern controller.
// Holds the action codes, the one-hot mode type and its output encoding.
// No dependencies.
package lbpc_pkg;

  // action codes carried on the input tuser
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_ON    = 3'd1;
  localparam logic [2:0] ACT_OFF   = 3'd2;
  localparam logic [2:0] ACT_FLICK = 3'd3;
  localparam logic [2:0] ACT_BLINK = 3'd4;

  // mode codes as shown in the result item
  localparam logic [1:0] MODE_CODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_CODE_ON    = 2'd1;
  localparam logic [1:0] MODE_CODE_FLICK = 2'd2;
  localparam logic [1:0] MODE_CODE_BLINK = 2'd3;

  typedef enum logic [3:0] {
    MODE_OFF   = 4'b0001,
    MODE_ON    = 4'b0010,
    MODE_FLICK = 4'b0100,
    MODE_BLINK = 4'b1000
  } mode_e;

  // map the one-hot mode onto its 2-bit code
  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_OFF:   c = MODE_CODE_OFF;
      MODE_ON:    c = MODE_CODE_ON;
      MODE_FLICK: c = MODE_CODE_FLICK;
      MODE_BLINK: c = MODE_CODE_BLINK;
      default:    c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/led_blink_pattern_controller.sv @@
// LED blink pattern controller: drives one LED from commands and 1 ms ticks.
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the output register lets a new item in
// whenever the result register is empty or being taken in the same cycle.
// Reset (rst_ni low, asynchronous): mode off, LED low, all counters and limits
// zero, no result pending.
// Depends on lbpc_pkg.
module led_blink_pattern_controller
  import lbpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // [15:0] full_period, [39:16] timeout_ticks,
                                     // [55:40] toggle_limit
  input  logic [2:0]  s_axis_tuser,  // [2:0] action
  // result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] led_level, [2:1] mode_now,
                                     // [3] timed_out, [4] blink_done, [7:5] zero
);

  // Unpack the input item.
  logic [2:0]  action;
  logic [14:0] hp;
  logic [23:0] tmo;
  logic [15:0] lim;

  assign action = s_axis_tuser;
  assign hp     = s_axis_tdata[15:1];   // half of full_period
  assign tmo    = s_axis_tdata[39:16];
  assign lim    = s_axis_tdata[55:40];

  // Block state.
  mode_e       mode_q, mode_d;
  logic        led_q, led_d;
  logic [15:0] tick_q, tick_d;
  logic [14:0] half_q, half_d;
  logic [23:0] tmo_cnt_q, tmo_cnt_d;
  logic [23:0] tmo_lim_q, tmo_lim_d;
  logic [15:0] tgl_cnt_q, tgl_cnt_d;
  logic [15:0] tgl_tgt_q, tgl_tgt_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;

  logic        accept;
  logic        timed_out, blink_done;
  logic [15:0] tick_inc;
  logic        tick_due;
  logic [23:0] tmo_inc;
  logic [15:0] tgl_inc;

  // Take a new item whenever the result slot is free or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tick_inc = tick_q + 16'd1;
  assign tick_due = tick_inc >= {1'b0, half_q};
  assign tmo_inc  = tmo_cnt_q + 24'd1;
  assign tgl_inc  = tgl_cnt_q + 16'd1;

  // Next state for one item.
  always_comb begin
    mode_d     = mode_q;
    led_d      = led_q;
    tick_d     = tick_q;
    half_d     = half_q;
    tmo_cnt_d  = tmo_cnt_q;
    tmo_lim_d  = tmo_lim_q;
    tgl_cnt_d  = tgl_cnt_q;
    tgl_tgt_d  = tgl_tgt_q;
    timed_out  = 1'b0;
    blink_done = 1'b0;

    unique case (action)
      ACT_TICK: begin
        unique case (mode_q)
          MODE_FLICK: begin
            // toggle first, then let an expiring timeout force the LED off
            if (tick_due) begin
              tick_d = 16'd0;
              led_d  = ~led_q;
            end else begin
              tick_d = tick_inc;
            end
            if (tmo_lim_q != 24'd0) begin
              if (tmo_inc >= tmo_lim_q) begin
                tmo_cnt_d = 24'd0;
                led_d     = 1'b0;
                tick_d    = 16'd0;
                mode_d    = MODE_OFF;
                timed_out = 1'b1;
              end else begin
                tmo_cnt_d = tmo_inc;
              end
            end
          end
          MODE_BLINK: begin
            if (tick_due) begin
              tick_d = 16'd0;
              led_d  = ~led_q;
              if (tgl_inc >= tgl_tgt_q) begin
                tgl_cnt_d  = 16'd0;
                led_d      = 1'b0;
                mode_d     = MODE_OFF;
                blink_done = 1'b1;
              end else begin
                tgl_cnt_d = tgl_inc;
              end
            end else begin
              tick_d = tick_inc;
            end
          end
          default: begin
            // ticks while off or on change nothing
          end
        endcase
      end
      ACT_ON: begin
        led_d  = 1'b1;
        mode_d = MODE_ON;
      end
      ACT_OFF: begin
        led_d  = 1'b0;
        tick_d = 16'd0;
        mode_d = MODE_OFF;
      end
      ACT_FLICK: begin
        // drop a repeat of the running flick; the timeout count carries over
        if (!(mode_q == MODE_FLICK && hp == half_q && tmo == tmo_lim_q)) begin
          led_d     = 1'b1;
          tick_d    = 16'd0;
          half_d    = hp;
          tmo_lim_d = tmo;
          mode_d    = MODE_FLICK;
        end
      end
      ACT_BLINK: begin
        // blink starts dark with a fresh toggle count
        led_d     = 1'b0;
        tick_d    = 16'd0;
        half_d    = hp;
        tgl_tgt_d = lim;
        tgl_cnt_d = 16'd0;
        mode_d    = MODE_BLINK;
      end
      default: begin
        // unused action codes leave the state alone
      end
    endcase
  end

  // Result slot: load on accept, clear when taken without a refill.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, blink_done, timed_out, mode_code(mode_d), led_d};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      led_q       <= 1'b0;
      tick_q      <= 16'd0;
      half_q      <= 15'd0;
      tmo_cnt_q   <= 24'd0;
      tmo_lim_q   <= 24'd0;
      tgl_cnt_q   <= 16'd0;
      tgl_tgt_q   <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        mode_q    <= mode_d;
        led_q     <= led_d;
        tick_q    <= tick_d;
        half_q    <= half_d;
        tmo_cnt_q <= tmo_cnt_d;
        tmo_lim_q <= tmo_lim_d;
        tgl_cnt_q <= tgl_cnt_d;
        tgl_tgt_q <= tgl_tgt_d;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/core/lbpc_checker.sv @@
// Port-level checker for the LED blink pattern controller, bound to the top.
// Depends on lbpc_pkg and led_blink_pattern_controller.
module lbpc_assert
  import lbpc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every accepted item yields a result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // off mode always shows a dark LED
  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:1] == MODE_CODE_OFF |-> !m_axis_tdata[0])
    else $error("LED lit while off");

  // an expiry or blink end leaves the block off
  a_event_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3] || m_axis_tdata[4])
      |-> m_axis_tdata[2:1] == MODE_CODE_OFF && !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("event flag without turning off");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
    else $error("nonzero padding in result");

endmodule

bind led_blink_pattern_controller lbpc_assert u_lbpc_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/lbpc_checker.sv @@
// Checker for the LED blink pattern controller: watches both item channels,
// predicts each result item from the accepted input items and compares them.
// Depends on lbpc_pkg for the action and mode codes.
module lbpc_checker
  import lbpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [55:0] s_axis_tdata_i,  // [15:0] full_period, [39:16] timeout_ticks,
                                       // [55:40] toggle_limit
  input  logic [2:0]  s_axis_tuser_i,  // [2:0] action
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,  // [0] led_level, [2:1] mode_now,
                                       // [3] timed_out, [4] blink_done, [7:5] zero
  output int          err_count_o,
  output int          pending_o,
  output int          results_o,
  output int          timeouts_o,
  output int          blinks_done_o
);

  localparam int MAX_REPORTS = 10;

  // one result item, lowest bit last in the packed order
  typedef struct packed {
    logic       blink_done;
    logic       timed_out;
    logic [1:0] mode;
    logic       led;
  } led_status_t;

  led_status_t status_q[$];

  // predicted controller state
  logic [1:0]  mode_q;
  logic        led_q;
  logic [15:0] tick_q;
  logic [14:0] half_q;
  logic [23:0] tmo_cnt_q;
  logic [23:0] tmo_lim_q;
  logic [15:0] tgl_cnt_q;
  logic [15:0] tgl_tgt_q;

  function automatic void enter_off();
    led_q  = 1'b0;
    tick_q = '0;
    mode_q = MODE_CODE_OFF;
  endfunction

  // advance the tick counter; true when a toggle is due
  function automatic logic period_done();
    tick_q = tick_q + 16'd1;
    if (tick_q >= {1'b0, half_q}) begin
      tick_q = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic led_status_t predict_status(input logic [2:0] act, input logic [55:0] d);
    led_status_t r;
    logic [14:0] hp;
    logic [23:0] tmo;
    logic [15:0] lim;
    hp  = d[15:1];
    tmo = d[39:16];
    lim = d[55:40];
    r   = '0;
    case (act)
      ACT_TICK: begin
        if (mode_q == MODE_CODE_FLICK) begin
          if (period_done()) led_q = ~led_q;
          // a due toggle comes first, then the timeout may switch off
          if (tmo_lim_q != '0) begin
            tmo_cnt_q = tmo_cnt_q + 24'd1;
            if (tmo_cnt_q >= tmo_lim_q) begin
              tmo_cnt_q = '0;
              enter_off();
              r.timed_out = 1'b1;
            end
          end
        end else if (mode_q == MODE_CODE_BLINK) begin
          if (period_done()) begin
            led_q     = ~led_q;
            tgl_cnt_q = tgl_cnt_q + 16'd1;
            if (tgl_cnt_q >= tgl_tgt_q) begin
              tgl_cnt_q = '0;
              enter_off();
              r.blink_done = 1'b1;
            end
          end
        end
      end
      ACT_ON: begin
        led_q  = 1'b1;
        mode_q = MODE_CODE_ON;
      end
      ACT_OFF: enter_off();
      ACT_FLICK: begin
        // drop a repeat of the running flick; keep the timeout count on restart
        if (!(mode_q == MODE_CODE_FLICK && hp == half_q && tmo == tmo_lim_q)) begin
          led_q     = 1'b1;
          tick_q    = '0;
          half_q    = hp;
          tmo_lim_q = tmo;
          mode_q    = MODE_CODE_FLICK;
        end
      end
      ACT_BLINK: begin
        enter_off();
        half_q    = hp;
        tgl_tgt_q = lim;
        tgl_cnt_q = '0;
        mode_q    = MODE_CODE_BLINK;
      end
      default: ;
    endcase
    r.led  = led_q;
    r.mode = mode_q;
    return r;
  endfunction

  function automatic void note_failure(input string what);
    err_count_o++;
    if (err_count_o <= MAX_REPORTS) $display("%s", what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    led_status_t want;
    led_status_t got;
    if (!rst_ni) begin
      status_q.delete();
      mode_q        = MODE_CODE_OFF;
      led_q         = 1'b0;
      tick_q        = '0;
      half_q        = '0;
      tmo_cnt_q     = '0;
      tmo_lim_q     = '0;
      tgl_cnt_q     = '0;
      tgl_tgt_q     = '0;
      err_count_o   = 0;
      pending_o     = 0;
      results_o     = 0;
      timeouts_o    = 0;
      blinks_done_o = 0;
    end else begin
      // take the result first: it belongs to an earlier input item
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_o++;
        got = m_axis_tdata_i[4:0];
        if (status_q.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected: data=%02h",
                                 results_o, m_axis_tdata_i));
        end else begin
          want = status_q.pop_front();
          if (want.timed_out) timeouts_o++;
          if (want.blink_done) blinks_done_o++;
          if ({m_axis_tdata_i[7:5], got} !== {3'b000, want}) begin
            note_failure($sformatf(
              "result %0d mismatch: expected led=%0b mode=%0d timed_out=%0b blink_done=%0b pad=0, got led=%0b mode=%0d timed_out=%0b blink_done=%0b pad=%0h",
              results_o, want.led, want.mode, want.timed_out, want.blink_done,
              got.led, got.mode, got.timed_out, got.blink_done, m_axis_tdata_i[7:5]));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        status_q.push_back(predict_status(s_axis_tuser_i, s_axis_tdata_i));
      end
      pending_o = status_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// Top of the LED blink pattern controller test: clock, reset, stimulus and verdict.
// Depends on lbpc_pkg, the controller and lbpc_checker, which predicts and compares.
module testbench;
  import lbpc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES = 8;       // a result is registered in the cycle after its item is taken
  localparam int RANDOM_ITEMS  = 1150;
  localparam int PHASES        = 4;
  // action codes the controller does not use
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;  // [15:0] full_period, [39:16] timeout_ticks,
                                    // [55:40] toggle_limit
  logic [2:0]  s_axis_tuser  = '0;  // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] led_level, [2:1] mode_now,
                                    // [3] timed_out, [4] blink_done, [7:5] zero

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int items_sent = 0;
  int err_count, pending, results, timeouts, blinks_done;

  // last flick settings, kept to send repeat flick commands
  logic [15:0] flick_fp  = '0;
  logic [23:0] flick_tmo = '0;

  led_blink_pattern_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lbpc_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .err_count_o     (err_count),
    .pending_o       (pending),
    .results_o       (results),
    .timeouts_o      (timeouts),
    .blinks_done_o   (blinks_done)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // stall the result channel at the rate of the current phase
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // end the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one item, called and returning at a falling edge. Hold valid across
  // back-to-back items; drop it only for idle cycles.
  task automatic send_item(input logic [2:0] act, input logic [15:0] fp,
                           input logic [23:0] tmo, input logic [15:0] lim);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {lim, tmo, fp};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // hold off the sender until every expected result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // mostly small values so toggles and expiries happen often, now and then any value
  function automatic logic [15:0] short_or_any16(input int unsigned short_max);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(short_max));
  endfunction

  task automatic send_random();
    int unsigned pick;
    logic [2:0]  act;
    logic [15:0] fp;
    logic [23:0] tmo;
    logic [15:0] lim;
    pick = $urandom_range(99);
    // fields an action ignores still carry random bits
    fp  = 16'($urandom);
    tmo = 24'($urandom);
    lim = 16'($urandom);
    if (pick < 62) begin
      act = ACT_TICK;
    end else if (pick < 72) begin
      act = ACT_FLICK;
      fp  = short_or_any16(9);
      case ($urandom_range(9))
        0, 1, 2: tmo = '0;
        3:       tmo = 24'($urandom);
        default: tmo = 24'($urandom_range(25, 1));
      endcase
      flick_fp  = fp;
      flick_tmo = tmo;
    end else if (pick < 76) begin
      // repeat the last flick; flipping bit 0 keeps the half period
      act = ACT_FLICK;
      fp  = flick_fp ^ 16'($urandom_range(1));
      tmo = flick_tmo;
    end else if (pick < 84) begin
      act = ACT_BLINK;
      fp  = short_or_any16(9);
      lim = short_or_any16(5);
    end else if (pick < 88) begin
      act = ACT_ON;
    end else if (pick < 94) begin
      act = ACT_OFF;
    end else begin
      act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
    end
    send_item(act, fp, tmo, lim);
  endtask

  initial begin
    int phase_idle[PHASES];
    int phase_stall[PHASES];
    phase_idle  = '{0, 56, 0, 36};
    phase_stall = '{0, 0, 56, 36};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling
    send_item(ACT_TICK,  16'hFFFF, 24'hFFFFFF, 16'hFFFF);  // tick while off
    send_item(ACT_ON,    '0, '0, '0);
    send_item(ACT_TICK,  '0, '0, '0);                    // tick while on
    send_item(ACT_SPARE_LAST, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    send_item(ACT_OFF,   '0, '0, '0);
    send_item(ACT_FLICK, 16'd4, 24'd5, '0);
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_TICK,  '0, '0, '0);                    // first toggle
    send_item(ACT_FLICK, 16'd5, 24'd5, '0);              // repeat, same half period
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_FLICK, 16'd4, 24'd2, '0);              // new limit below the count
    send_item(ACT_TICK,  '0, '0, '0);                    // expires at once
    send_item(ACT_FLICK, 16'd2, 24'd1, '0);
    send_item(ACT_TICK,  '0, '0, '0);                    // toggle, then expiry
    send_item(ACT_FLICK, 16'd1, 24'd0, '0);              // zero half period, no timeout
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_BLINK, 16'd0, '0, 16'd0);              // zero toggle target
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_BLINK, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_FLICK, 16'hFFFF, 24'hFFFFFF, '0);
    send_item(ACT_TICK,  16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    send_item(ACT_BLINK, 16'd3, '0, 16'd2);
    send_item(ACT_TICK,  '0, '0, '0);
    send_item(ACT_TICK,  '0, '0, '0);                    // blink ends here
    drain_results();

    // random part, one idle and stall pattern per phase, sender paused between phases
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      repeat (RANDOM_ITEMS / PHASES) send_random();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d items (directed, then random over %0d idle/stall phases) in %0d cycles",
             items_sent, PHASES, cycles);
    $display("checked %0d results: %0d flick timeouts, %0d blink completions, %0d mismatches",
             results, timeouts, blinks_done, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lbpc_pkg.sv
rtl/core/led_blink_pattern_controller.sv
rtl/core/lbpc_checker.sv
sim/lbpc_checker.sv
sim/testbench.sv
